FILE: hdl/gnss_pkg.sv
package gnss_pkg;

   localparam int ROWS_DEFAULT = 64;
   localparam int COLS_DEFAULT = 64;

   localparam int ROW_BITS_W = 64;
   localparam int DEP_W      = 64;
   localparam int CCOUNT_W   = 7;
   localparam int RANK_W     = 7;

   localparam logic [CCOUNT_W-1:0] CCOUNT_RESET = 7'd64;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_COL,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_SWAP_RD,
      ST_SWAP_WR,
      ST_PIV_WR,
      ST_ELIM_RD,
      ST_ELIM_WR,
      ST_EMIT_RD,
      ST_EMIT_OUT,
      ST_EMIT_NONE
   } state_type;

endpackage

FILE: hdl/gnss_ram.sv
module gnss_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/gnss_seq.sv
module gnss_seq import gnss_pkg::*; #(
   parameter int ROWS = ROWS_DEFAULT,
   parameter int COLS = COLS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [ROW_BITS_W-1:0] req_row_bits,
   input  logic                  req_last_row,
   input  logic [CCOUNT_W-1:0]   column_count,
   output logic                  rsp_strobe,
   output logic [DEP_W-1:0]      rsp_dependency,
   output logic                  rsp_found,
   output logic [RANK_W-1:0]     rsp_rank,
   output logic                  rsp_overflow,
   output logic                  rsp_last_result
);

   localparam int AW  = $clog2(ROWS);
   localparam int CW  = $clog2(ROWS + 1);
   localparam int CLW = $clog2(COLS + 1);
   localparam int CIW = (COLS > 1) ? $clog2(COLS) : 1;
   localparam int WW  = ROWS + COLS;
   localparam logic [CCOUNT_W-1:0] COLS_CC = CCOUNT_W'(COLS);
   localparam logic [CW-1:0] ROWS_C = CW'(ROWS);
   localparam logic [CW-1:0] ONE_C  = CW'(1);

   state_type state_ff, state_in;
   logic [CW-1:0]  n_ff, n_in;
   logic           drop_ff, drop_in;
   logic [CLW-1:0] col_ff, col_in;
   logic [CLW-1:0] lim_ff, lim_in;
   logic [CW-1:0]  rank_ff, rank_in;
   logic [CW-1:0]  ptr_ff, ptr_in;
   logic [CW-1:0]  piv_idx_ff, piv_idx_in;
   logic [WW-1:0]  pivot_ff, pivot_in;

   logic            wr_en;
   logic [AW-1:0]   wr_addr;
   logic [WW-1:0]   wr_data;
   logic [AW-1:0]   rd_addr;
   logic [WW-1:0]   rd_data;

   logic            accept;
   logic            col_bit;
   logic [COLS-1:0] rd_row;
   logic [CW-1:0]   ptr_next;
   logic [CW-1:0]   piv_next;
   logic [CCOUNT_W-1:0] lim_cc;
   logic [ROWS-1:0] tag;

   gnss_ram #(
      .WIDTH(WW),
      .DEPTH(ROWS),
      .AW   (AW)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign accept   = start && (state_ff == ST_IDLE);
   assign busy     = (state_ff != ST_IDLE);
   assign rd_row   = rd_data[COLS-1:0];
   assign col_bit  = rd_row[col_ff[CIW-1:0]];
   assign ptr_next = ptr_ff + ONE_C;
   assign piv_next = piv_idx_ff + ONE_C;
   assign lim_cc   = (column_count > COLS_CC) ? COLS_CC : column_count;
   assign tag      = ROWS'(1) << n_ff[AW-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_last_row) state_in = ST_COL;
         end
         ST_COL: begin
            if ((col_ff >= lim_ff) || (rank_ff >= n_ff)) begin
               state_in = (rank_ff >= n_ff) ? ST_EMIT_NONE : ST_EMIT_RD;
            end else begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_SCAN_RD: state_in = ST_SCAN_CHK;
         ST_SCAN_CHK: begin
            if (col_bit) begin
               state_in = (ptr_ff == rank_ff) ? ST_PIV_WR : ST_SWAP_RD;
            end else if (ptr_next >= n_ff) begin
               state_in = ST_COL;
            end else begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_SWAP_RD: state_in = ST_SWAP_WR;
         ST_SWAP_WR: state_in = ST_PIV_WR;
         ST_PIV_WR:  state_in = (piv_next >= n_ff) ? ST_COL : ST_ELIM_RD;
         ST_ELIM_RD: state_in = ST_ELIM_WR;
         ST_ELIM_WR: state_in = (ptr_next >= n_ff) ? ST_COL : ST_ELIM_RD;
         ST_EMIT_RD: state_in = ST_EMIT_OUT;
         ST_EMIT_OUT: state_in = (ptr_next == n_ff) ? ST_IDLE : ST_EMIT_RD;
         ST_EMIT_NONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath registers
   always_comb begin
      n_in       = n_ff;
      drop_in    = drop_ff;
      col_in     = col_ff;
      lim_in     = lim_ff;
      rank_in    = rank_ff;
      ptr_in     = ptr_ff;
      piv_idx_in = piv_idx_ff;
      pivot_in   = pivot_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (n_ff < ROWS_C) n_in = n_ff + ONE_C;
               else drop_in = 1'b1;
               col_in  = '0;
               rank_in = '0;
               lim_in  = CLW'(lim_cc);
            end
         end
         ST_COL: begin
            ptr_in = rank_ff;
         end
         ST_SCAN_CHK: begin
            if (col_bit) begin
               pivot_in   = rd_data;
               piv_idx_in = ptr_ff;
            end else begin
               ptr_in = ptr_next;
               if (ptr_next >= n_ff) col_in = col_ff + CLW'(1);
            end
         end
         ST_PIV_WR: begin
            ptr_in = piv_next;
            if (piv_next >= n_ff) begin
               rank_in = rank_ff + ONE_C;
               col_in  = col_ff + CLW'(1);
            end
         end
         ST_ELIM_WR: begin
            ptr_in = ptr_next;
            if (ptr_next >= n_ff) begin
               rank_in = rank_ff + ONE_C;
               col_in  = col_ff + CLW'(1);
            end
         end
         ST_EMIT_OUT: begin
            ptr_in = ptr_next;
            if (ptr_next == n_ff) begin
               n_in    = '0;
               drop_in = 1'b0;
            end
         end
         ST_EMIT_NONE: begin
            n_in    = '0;
            drop_in = 1'b0;
         end
         default: ;
      endcase
   end

   // memory control and result outputs
   always_comb begin
      wr_en           = 1'b0;
      wr_addr         = ptr_ff[AW-1:0];
      wr_data         = rd_data ^ pivot_ff;
      rd_addr         = ptr_ff[AW-1:0];
      rsp_strobe      = 1'b0;
      rsp_found       = 1'b0;
      rsp_dependency  = '0;
      rsp_last_result = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            wr_en   = accept && (n_ff < ROWS_C);
            wr_addr = n_ff[AW-1:0];
            wr_data = {tag, req_row_bits[COLS-1:0]};
         end
         ST_SWAP_RD: rd_addr = rank_ff[AW-1:0];
         ST_SWAP_WR: begin
            // old row at rank moves to where the pivot was
            wr_en   = 1'b1;
            wr_addr = piv_idx_ff[AW-1:0];
            wr_data = rd_data;
         end
         ST_PIV_WR: begin
            wr_en   = 1'b1;
            wr_addr = rank_ff[AW-1:0];
            wr_data = pivot_ff;
         end
         ST_ELIM_WR: wr_en = col_bit;
         ST_EMIT_OUT: begin
            rsp_strobe      = 1'b1;
            rsp_found       = 1'b1;
            rsp_dependency  = DEP_W'(rd_data[WW-1:COLS]);
            rsp_last_result = (ptr_next == n_ff);
         end
         ST_EMIT_NONE: begin
            rsp_strobe      = 1'b1;
            rsp_last_result = 1'b1;
         end
         default: ;
      endcase
   end

   assign rsp_rank     = RANK_W'(rank_ff);
   assign rsp_overflow = drop_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         n_ff     <= '0;
         drop_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         n_ff     <= n_in;
         drop_ff  <= drop_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff     <= col_in;
      lim_ff     <= lim_in;
      rank_ff    <= rank_in;
      ptr_ff     <= ptr_in;
      piv_idx_ff <= piv_idx_in;
      pivot_ff   <= pivot_in;
   end

endmodule

FILE: hdl/gf2_null_space_solver_top.sv
// GF(2) null-space solver.
// Requests: rows of exponent parities on req_row_bits, one per cycle while
// busy is low; a request is taken on a clock edge with start high and busy low.
// Each loaded row is tagged with its arrival index. A request with
// req_last_row set ends the batch and starts elimination; busy stays high
// until all results are out. Rows past ROWS are dropped and flagged.
// Results: rsp_strobe marks each result for one cycle; the receiver must take
// it, there is no back pressure. One result per zero row left after
// elimination, or a single result with rsp_found low if there is none;
// rsp_last_result marks the end of the batch.
// Elimination runs on one row memory with one read and one write port, one
// row per access: per column a set-up, a read and a check per row scanned,
// a pivot write (a read and two writes with a swap) and a read and a write
// per row below the pivot; each result is read out of memory, a lone found-low
// result is not. The read port sets all this. csr_column_count must be written
// by the user through csr_valid/csr_ready while idle, which the block does not
// enforce. Reset sets it to 64 and empties the batch. No clearing pass is needed.
module gf2_null_space_solver_top import gnss_pkg::*; #(
   parameter int ROWS = ROWS_DEFAULT,
   parameter int COLS = COLS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [ROW_BITS_W-1:0] req_row_bits,
   input  logic                  req_last_row,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CCOUNT_W-1:0]   csr_column_count,
   output logic                  rsp_strobe,
   output logic [DEP_W-1:0]      rsp_dependency,
   output logic                  rsp_found,
   output logic [RANK_W-1:0]     rsp_rank,
   output logic                  rsp_overflow,
   output logic                  rsp_last_result
);

   logic [CCOUNT_W-1:0] column_count_ff, column_count_in;

   assign csr_ready       = 1'b1;
   assign column_count_in = (csr_valid && csr_ready) ? csr_column_count : column_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= CCOUNT_RESET;
      end else begin
         column_count_ff <= column_count_in;
      end
   end

   gnss_seq #(
      .ROWS(ROWS),
      .COLS(COLS)
   ) u_seq (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_row_bits   (req_row_bits),
      .req_last_row   (req_last_row),
      .column_count   (column_count_ff),
      .rsp_strobe     (rsp_strobe),
      .rsp_dependency (rsp_dependency),
      .rsp_found      (rsp_found),
      .rsp_rank       (rsp_rank),
      .rsp_overflow   (rsp_overflow),
      .rsp_last_result(rsp_last_result)
   );

endmodule
